### design/ddpi_pkg.sv
// Shared types, register indexes, microcode field codes and Q16.16 constants
// for the differential-drive wheel PI controller. No dependencies.
`timescale 1ns / 1ps

package ddpi_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int PcW      = 4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_HALF_TRACK       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_INV_RADIUS_LEFT  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_INV_RADIUS_RIGHT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN        = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN       = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_STEP_SCALE = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_LIMIT      = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_COMMAND_TIMEOUT  = 3'd7;

    // Q16.16 constants
    localparam logic signed [19:0] ERR_SAT   = 20'sd327680;   // 5.0
    localparam logic signed [31:0] MIN_SP    = 32'sd3277;     // 0.05
    localparam logic signed [23:0] DRIVE_SAT = 24'sd6553600;  // 100.0

    // multiplier operand A select
    localparam logic [2:0] MA_ANG   = 3'd0;
    localparam logic [2:0] MA_VLO   = 3'd1;
    localparam logic [2:0] MA_VHI   = 3'd2;
    localparam logic [2:0] MA_ERR   = 3'd3;
    localparam logic [2:0] MA_INTEG = 3'd4;

    // multiplier operand B select
    localparam logic [2:0] MB_HTRK  = 3'd0;
    localparam logic [2:0] MB_INVR  = 3'd1;
    localparam logic [2:0] MB_STEP  = 3'd2;
    localparam logic [2:0] MB_PGAIN = 3'd3;
    localparam logic [2:0] MB_IGAIN = 3'd4;

    // datapath register operations
    localparam logic [3:0] ALU_NONE   = 4'd0;
    localparam logic [3:0] ALU_VSUM   = 4'd1;
    localparam logic [3:0] ALU_ACC_LO = 4'd2;
    localparam logic [3:0] ALU_WHEEL  = 4'd3;
    localparam logic [3:0] ALU_ERR    = 4'd4;
    localparam logic [3:0] ALU_INTEG  = 4'd5;
    localparam logic [3:0] ALU_DRV_P  = 4'd6;
    localparam logic [3:0] ALU_DRV_I  = 4'd7;
    localparam logic [3:0] ALU_OUT    = 4'd8;

    // jump conditions
    localparam logic [1:0] JC_NONE  = 2'd0;
    localparam logic [1:0] JC_LOOP4 = 2'd1;
    localparam logic [1:0] JC_STALE = 2'd2;
    localparam logic [1:0] JC_LEFT  = 2'd3;

    typedef struct packed {
        logic signed [31:0] fb_linear;
        logic signed [31:0] fb_angular;
        logic signed [31:0] set_linear;
        logic signed [31:0] set_angular;
        logic        [15:0] command_age;
    } t_in;

    typedef struct packed {
        logic signed [23:0] drive_left;
        logic signed [23:0] drive_right;
        logic signed [31:0] wheel_meas_left;
        logic signed [31:0] wheel_meas_right;
        logic signed [31:0] wheel_set_left;
        logic signed [31:0] wheel_set_right;
        logic               timed_out;
    } t_out;

    typedef struct packed {
        logic        [30:0] half_track;
        logic        [30:0] inv_radius_left;
        logic        [30:0] inv_radius_right;
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic        [30:0] integ_step_scale;
        logic        [30:0] integ_limit;
        logic        [15:0] command_timeout;
    } t_cfg;

    // one microcode word
    typedef struct packed {
        logic           mul_en;
        logic [2:0]     mul_a;
        logic [2:0]     mul_b;
        logic [3:0]     alu_op;
        logic [1:0]     jump;
        logic           idx_inc;
        logic [PcW-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic       start;
        logic       mul_en;
        logic [2:0] mul_a;
        logic [2:0] mul_b;
        logic [3:0] alu_op;
        logic [1:0] idx;
    } t_dp_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic stale;
        logic out_blocked;
    } t_dp_stat;

endpackage

### design/ddpi_cfg.sv
// Configuration register bank with reset values.
// Depends on ddpi_pkg.
`timescale 1ns / 1ps

module ddpi_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ddpi_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ddpi_pkg::CfgDataW-1:0] i_cfg_data,
    output ddpi_pkg::t_cfg                o_cfg
);
    import ddpi_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_track       <= 31'd6554;
            r_cfg.inv_radius_left  <= 31'd2184533;
            r_cfg.inv_radius_right <= 31'd2184533;
            r_cfg.prop_gain        <= -32'sd262144;
            r_cfg.integ_gain       <= -32'sd3277;
            r_cfg.integ_step_scale <= 31'd6553600;
            r_cfg.integ_limit      <= 31'd65536000;
            r_cfg.command_timeout  <= 16'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_TRACK:       r_cfg.half_track       <= i_cfg_data[30:0];
                CFG_INV_RADIUS_LEFT:  r_cfg.inv_radius_left  <= i_cfg_data[30:0];
                CFG_INV_RADIUS_RIGHT: r_cfg.inv_radius_right <= i_cfg_data[30:0];
                CFG_PROP_GAIN:        r_cfg.prop_gain        <= i_cfg_data;
                CFG_INTEG_GAIN:       r_cfg.integ_gain       <= i_cfg_data;
                CFG_INTEG_STEP_SCALE: r_cfg.integ_step_scale <= i_cfg_data[30:0];
                CFG_INTEG_LIMIT:      r_cfg.integ_limit      <= i_cfg_data[30:0];
                CFG_COMMAND_TIMEOUT:  r_cfg.command_timeout  <= i_cfg_data[15:0];
            endcase
        end
    end

endmodule

### design/ddpi_seq.sv
// Microcode sequencer: program ROM, step counter, loop index and jumps.
// Depends on ddpi_pkg.
`timescale 1ns / 1ps

module ddpi_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_busy,
    input  ddpi_pkg::t_dp_stat i_stat,
    output ddpi_pkg::t_dp_ctrl o_ctrl
);
    import ddpi_pkg::*;

    function automatic t_uword uw(input logic mul_en, input logic [2:0] mul_a,
                                  input logic [2:0] mul_b, input logic [3:0] alu_op,
                                  input logic [1:0] jump, input logic idx_inc,
                                  input logic [PcW-1:0] target);
        t_uword w;
        w.mul_en  = mul_en;
        w.mul_a   = mul_a;
        w.mul_b   = mul_b;
        w.alu_op  = alu_op;
        w.jump    = jump;
        w.idx_inc = idx_inc;
        w.target  = target;
        return w;
    endfunction

    // wheel-speed loop runs four times (meas L/R, set L/R), drive loop twice unless stale
    function automatic t_uword rom(input logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = uw(1'b1, MA_ANG,   MB_HTRK,  ALU_NONE,   JC_NONE,  1'b0, 4'd0);
            4'd1:    w = uw(1'b0, MA_ANG,   MB_HTRK,  ALU_VSUM,   JC_NONE,  1'b0, 4'd0);
            4'd2:    w = uw(1'b1, MA_VLO,   MB_INVR,  ALU_NONE,   JC_NONE,  1'b0, 4'd0);
            4'd3:    w = uw(1'b1, MA_VHI,   MB_INVR,  ALU_ACC_LO, JC_NONE,  1'b0, 4'd0);
            4'd4:    w = uw(1'b0, MA_ANG,   MB_HTRK,  ALU_WHEEL,  JC_LOOP4, 1'b1, 4'd0);
            4'd5:    w = uw(1'b0, MA_ANG,   MB_HTRK,  ALU_NONE,   JC_STALE, 1'b0, 4'd11);
            4'd6:    w = uw(1'b0, MA_ERR,   MB_STEP,  ALU_ERR,    JC_NONE,  1'b0, 4'd0);
            4'd7:    w = uw(1'b1, MA_ERR,   MB_STEP,  ALU_NONE,   JC_NONE,  1'b0, 4'd0);
            4'd8:    w = uw(1'b1, MA_ERR,   MB_PGAIN, ALU_INTEG,  JC_NONE,  1'b0, 4'd0);
            4'd9:    w = uw(1'b1, MA_INTEG, MB_IGAIN, ALU_DRV_P,  JC_NONE,  1'b0, 4'd0);
            4'd10:   w = uw(1'b0, MA_INTEG, MB_IGAIN, ALU_DRV_I,  JC_LEFT,  1'b1, 4'd6);
            4'd11:   w = uw(1'b0, MA_ANG,   MB_HTRK,  ALU_OUT,    JC_NONE,  1'b0, 4'd0);
            default: w = uw(1'b0, MA_ANG,   MB_HTRK,  ALU_OUT,    JC_NONE,  1'b0, 4'd0);
        endcase
        return w;
    endfunction

    logic           r_busy;
    logic [PcW-1:0] r_pc;
    logic [1:0]     r_idx;
    t_uword         w_uw;
    logic           w_taken;
    logic           w_start;

    assign w_uw    = rom(r_pc);
    assign w_start = i_in_valid && !r_busy;
    assign o_busy  = r_busy;

    always_comb begin
        unique case (w_uw.jump)
            JC_NONE:  w_taken = 1'b0;
            JC_LOOP4: w_taken = (r_idx != 2'd3);
            JC_STALE: w_taken = i_stat.stale;
            JC_LEFT:  w_taken = !r_idx[0];
        endcase
    end

    always_comb begin
        o_ctrl.start  = w_start;
        o_ctrl.mul_en = r_busy && w_uw.mul_en;
        o_ctrl.mul_a  = w_uw.mul_a;
        o_ctrl.mul_b  = w_uw.mul_b;
        o_ctrl.alu_op = r_busy ? w_uw.alu_op : ALU_NONE;
        o_ctrl.idx    = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_idx  <= '0;
        end else if (!r_busy) begin
            if (w_start) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                r_idx  <= '0;
            end
        end else if (w_uw.alu_op == ALU_OUT) begin
            // hold on the last step until the result register frees up
            if (!i_stat.out_blocked) begin
                r_busy <= 1'b0;
                r_pc   <= '0;
            end
        end else begin
            r_pc <= w_taken ? w_uw.target : r_pc + 1'b1;
            if (w_uw.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

### design/ddpi_dpath.sv
// Datapath: input latch, shared 33x33 multiplier, working registers,
// integrators and result register. Depends on ddpi_pkg.
`timescale 1ns / 1ps

module ddpi_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddpi_pkg::t_cfg     i_cfg,
    input  ddpi_pkg::t_dp_ctrl i_ctrl,
    output ddpi_pkg::t_dp_stat o_stat,
    input  ddpi_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ddpi_pkg::t_out     o_out
);
    import ddpi_pkg::*;

    // latched item
    logic signed [31:0] r_ml, r_ma, r_sl, r_sa;
    logic               r_stale;

    // working registers
    logic signed [65:0] r_prod;
    logic signed [47:0] r_v;
    logic signed [79:0] r_acc;
    logic signed [31:0] r_wml, r_wmr, r_wsl, r_wsr;
    logic signed [19:0] r_err;
    logic signed [31:0] r_integ;
    logic signed [49:0] r_drv;
    logic signed [23:0] r_dl, r_dr;
    logic signed [31:0] r_acc_l, r_acc_r;

    logic               r_out_valid;
    t_out               r_out;

    logic               w_right;
    logic signed [31:0] w_lin, w_ang;
    logic        [30:0] w_invr;
    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [49:0] w_prod_q;
    logic signed [47:0] w_t, w_lin48;
    logic signed [79:0] w_hi, w_asum;
    logic signed [63:0] w_aq;
    logic signed [31:0] w_wheel;
    logic signed [31:0] w_wm, w_ws, w_accw;
    logic signed [32:0] w_diff;
    logic signed [19:0] w_err;
    logic signed [50:0] w_isum, w_lim;
    logic signed [31:0] w_integ;
    logic signed [50:0] w_dsum;
    logic signed [23:0] w_drive;
    logic               w_blocked;

    assign w_right = i_ctrl.idx[0];
    assign w_lin   = i_ctrl.idx[1] ? r_sl : r_ml;
    assign w_ang   = i_ctrl.idx[1] ? r_sa : r_ma;
    assign w_invr  = w_right ? i_cfg.inv_radius_right : i_cfg.inv_radius_left;

    always_comb begin
        unique case (i_ctrl.mul_a)
            MA_ANG:   w_mul_a = {w_ang[31], w_ang};
            MA_VLO:   w_mul_a = {9'd0, r_v[23:0]};
            MA_VHI:   w_mul_a = {{9{r_v[47]}}, r_v[47:24]};
            MA_ERR:   w_mul_a = {{13{r_err[19]}}, r_err};
            MA_INTEG: w_mul_a = {r_integ[31], r_integ};
            default:  w_mul_a = '0;
        endcase
        unique case (i_ctrl.mul_b)
            MB_HTRK:  w_mul_b = {2'b00, i_cfg.half_track};
            MB_INVR:  w_mul_b = {2'b00, w_invr};
            MB_STEP:  w_mul_b = {2'b00, i_cfg.integ_step_scale};
            MB_PGAIN: w_mul_b = {i_cfg.prop_gain[31], i_cfg.prop_gain};
            MB_IGAIN: w_mul_b = {i_cfg.integ_gain[31], i_cfg.integ_gain};
            default:  w_mul_b = '0;
        endcase
    end

    // every product shifts right by 16, floor rounding
    assign w_prod_q = r_prod[65:16];

    // body-to-wheel: v = lin -/+ ang*half_track
    assign w_t     = w_prod_q[47:0];
    assign w_lin48 = {{16{w_lin[31]}}, w_lin};

    // v*invr as high partial (v[47:24]) shifted in on top of low partial
    assign w_hi   = {r_prod[55:0], 24'd0};
    assign w_asum = r_acc + w_hi;
    assign w_aq   = w_asum[79:16];

    always_comb begin
        if (w_aq[63] && !(&w_aq[62:31])) begin
            w_wheel = 32'sh8000_0000;
        end else if (!w_aq[63] && (|w_aq[62:31])) begin
            w_wheel = 32'sh7fff_ffff;
        end else begin
            w_wheel = w_aq[31:0];
        end
    end

    assign w_wm   = w_right ? r_wmr : r_wml;
    assign w_ws   = w_right ? r_wsr : r_wsl;
    assign w_accw = w_right ? r_acc_r : r_acc_l;
    assign w_diff = {w_wm[31], w_wm} - {w_ws[31], w_ws};

    always_comb begin
        if (w_diff > ERR_SAT) begin
            w_err = ERR_SAT;
        end else if (w_diff < -ERR_SAT) begin
            w_err = -ERR_SAT;
        end else begin
            w_err = w_diff[19:0];
        end
    end

    assign w_isum = {{19{w_accw[31]}}, w_accw} + {w_prod_q[49], w_prod_q};
    assign w_lim  = {20'd0, i_cfg.integ_limit};

    always_comb begin
        if (w_ws < MIN_SP && w_ws > -MIN_SP) begin
            w_integ = '0;
        end else if (w_isum > w_lim) begin
            w_integ = w_lim[31:0];
        end else if (w_isum < -w_lim) begin
            w_integ = -w_lim[31:0];
        end else begin
            w_integ = w_isum[31:0];
        end
    end

    assign w_dsum = {r_drv[49], r_drv} + {w_prod_q[49], w_prod_q};

    always_comb begin
        if (w_dsum > DRIVE_SAT) begin
            w_drive = DRIVE_SAT;
        end else if (w_dsum < -DRIVE_SAT) begin
            w_drive = -DRIVE_SAT;
        end else begin
            w_drive = w_dsum[23:0];
        end
    end

    assign w_blocked          = r_out_valid && i_out_stall;
    assign o_stat.stale       = r_stale;
    assign o_stat.out_blocked = w_blocked;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_ml    <= i_in.fb_linear;
            r_ma    <= i_in.fb_angular;
            r_sl    <= i_in.set_linear;
            r_sa    <= i_in.set_angular;
            r_stale <= i_in.command_age > i_cfg.command_timeout;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        unique case (i_ctrl.alu_op)
            ALU_VSUM:   r_v <= w_right ? w_lin48 + w_t : w_lin48 - w_t;
            ALU_ACC_LO: r_acc <= {{14{r_prod[65]}}, r_prod};
            ALU_WHEEL: begin
                unique case (i_ctrl.idx)
                    2'd0: r_wml <= w_wheel;
                    2'd1: r_wmr <= w_wheel;
                    2'd2: r_wsl <= w_wheel;
                    2'd3: r_wsr <= w_wheel;
                endcase
            end
            ALU_ERR:    r_err <= w_err;
            ALU_INTEG:  r_integ <= w_integ;
            ALU_DRV_P:  r_drv <= w_prod_q;
            ALU_DRV_I: begin
                if (w_right) begin
                    r_dr <= w_drive;
                end else begin
                    r_dl <= w_drive;
                end
            end
            ALU_OUT: begin
                if (!w_blocked) begin
                    r_out.drive_left       <= r_stale ? '0 : r_dl;
                    r_out.drive_right      <= r_stale ? '0 : r_dr;
                    r_out.wheel_meas_left  <= r_wml;
                    r_out.wheel_meas_right <= r_wmr;
                    r_out.wheel_set_left   <= r_wsl;
                    r_out.wheel_set_right  <= r_wsr;
                    r_out.timed_out        <= r_stale;
                end
            end
            default: ;
        endcase
    end

    // integrator state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.alu_op == ALU_DRV_I) begin
                if (w_right) begin
                    r_acc_r <= r_integ;
                end else begin
                    r_acc_l <= r_integ;
                end
            end
            if (i_ctrl.alu_op == ALU_OUT && !w_blocked) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### design/diff_drive_wheel_pi_control.sv
// Differential-drive wheel speed PI controller, Q16.16, microcoded.
// Each item runs the microcode program on the single shared multiplier (stale
// items skip the PI steps); no new item is taken (o_in_stall high) until the last
// has been written to the result register, which waits while the output stalls.
// Reset (synchronous, active low): registers take their defaults, integrators clear.
`timescale 1ns / 1ps

module diff_drive_wheel_pi_control (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ddpi_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ddpi_pkg::t_out                o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ddpi_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ddpi_pkg::CfgDataW-1:0] i_cfg_data
);
    import ddpi_pkg::*;

    t_cfg     w_cfg;
    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    logic     w_busy;

    assign o_in_stall = w_busy;

    ddpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ddpi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (w_busy),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    ddpi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
